/* rtl/lzd_pkg.sv */
// ----------------------------------------------------------------------------
// lzd_pkg
// Shared types and constants for the lzss window decompressor: channel
// payloads, the command format between parser and expander, state encodings.
// ----------------------------------------------------------------------------
package lzd_pkg;

    // history window
    localparam int WINDOW_DEPTH = 4096;
    localparam int WIN_AW       = $clog2(WINDOW_DEPTH);
    localparam int DIST_W       = WIN_AW + 1;

    // block size and token fields
    localparam int SIZE_W   = 24;
    localparam int CNT_W    = 5;
    localparam int LEN_BIAS = 3;

    // command queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    // input transaction
    typedef struct packed {
        logic [7:0] in_byte;
        logic       start_req;
    } in_item_t;

    // result transaction
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
        logic       empty_res;
    } out_item_t;

    // parser phase
    typedef enum logic [2:0] {
        FP_IDLE,
        FP_HEADER,
        FP_FLAG,
        FP_TOKEN,
        FP_REFLO
    } front_phase_t;

    // expander state
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_EMIT
    } back_state_t;

    // command kinds
    typedef enum logic [1:0] {
        CMD_BEGIN,
        CMD_LIT,
        CMD_REF,
        CMD_EMPTY
    } cmd_kind_t;

    // one command: byte count already clipped to the block size
    typedef struct packed {
        cmd_kind_t         kind;
        logic [7:0]        lit;
        logic [CNT_W-1:0]  count;
        logic [DIST_W-1:0] distance;
        logic              last;
    } cmd_t;

    // queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

endpackage

/* rtl/lzd_ram.sv */
// ----------------------------------------------------------------------------
// lzd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lzd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port, holds when not enabled
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/lzd_cmd_fifo.sv */
// ----------------------------------------------------------------------------
// lzd_cmd_fifo
// Short command queue between the stream parser and the window expander.
// ----------------------------------------------------------------------------
module lzd_cmd_fifo (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  lzd_pkg::cmd_t        push_cmd,
    input  logic                 pop,
    output lzd_pkg::cmd_t        head_cmd,
    output lzd_pkg::fifo_status_t status
);
    import lzd_pkg::*;

    cmd_t               mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_CW-1:0] count_reg;
    logic               do_push;
    logic               do_pop;

    assign status.full  = (count_reg == FIFO_CW'(FIFO_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head_cmd     = mem_reg[rd_ptr_reg];

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

/* rtl/lzd_front.sv */
// ----------------------------------------------------------------------------
// lzd_front
// Stream parser: takes the header, flag bytes and tokens, tracks the bytes
// still owed to the block and queues begin, empty and clipped literal/reference commands.
// ----------------------------------------------------------------------------
module lzd_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  lzd_pkg::in_item_t     s_data,
    output logic                  push,
    output lzd_pkg::cmd_t         push_cmd,
    input  lzd_pkg::fifo_status_t status
);
    import lzd_pkg::*;

    front_phase_t      phase_reg, phase_next;
    logic [1:0]        hdr_idx_reg, hdr_idx_next;
    logic [SIZE_W-1:0] remaining_reg, remaining_next;
    logic [7:0]        flag_reg, flag_next;
    logic [3:0]        tokens_reg, tokens_next;
    logic [7:0]        ref_high_reg, ref_high_next;

    logic              accept;
    logic [7:0]        b;
    logic [CNT_W-1:0]  ref_len;
    logic [DIST_W-1:0] ref_dist;
    logic              ref_clipped;
    logic              hdr_done;
    logic              size_zero;
    logic [3:0]        tokens_dec;

    assign s_ready = !status.full;
    assign accept  = s_valid && s_ready;
    assign b       = s_data.in_byte;

    // token field decode
    assign ref_len     = CNT_W'({1'b0, ref_high_reg[7:4]}) + CNT_W'(LEN_BIAS);
    assign ref_dist    = DIST_W'({ref_high_reg[3:0], b}) + DIST_W'(1);
    assign ref_clipped = (remaining_reg <= SIZE_W'(ref_len));
    assign hdr_done    = (hdr_idx_reg == 2'd3);
    assign size_zero   = (remaining_reg[15:0] == 16'd0) && (b == 8'd0);
    assign tokens_dec  = tokens_reg - 4'd1;

    // next phase
    always_comb begin
        phase_next = phase_reg;
        if (accept) begin
            if (s_data.start_req) begin
                phase_next = FP_HEADER;
            end else begin
                unique case (phase_reg)
                    FP_IDLE: phase_next = FP_IDLE;
                    FP_HEADER: begin
                        if (hdr_done) begin
                            phase_next = size_zero ? FP_IDLE : FP_FLAG;
                        end
                    end
                    FP_FLAG: phase_next = FP_TOKEN;
                    FP_TOKEN: begin
                        if (flag_reg[7]) begin
                            phase_next = FP_REFLO;
                        end else if (remaining_reg == SIZE_W'(1)) begin
                            phase_next = FP_IDLE;
                        end else begin
                            phase_next = (tokens_dec == '0) ? FP_FLAG : FP_TOKEN;
                        end
                    end
                    FP_REFLO: begin
                        if (ref_clipped) begin
                            phase_next = FP_IDLE;
                        end else begin
                            phase_next = (tokens_dec == '0) ? FP_FLAG : FP_TOKEN;
                        end
                    end
                    default: phase_next = FP_IDLE;
                endcase
            end
        end
    end

    // datapath and command outputs
    always_comb begin
        hdr_idx_next      = hdr_idx_reg;
        remaining_next    = remaining_reg;
        flag_next         = flag_reg;
        tokens_next       = tokens_reg;
        ref_high_next     = ref_high_reg;
        push              = 1'b0;
        push_cmd.kind     = CMD_LIT;
        push_cmd.lit      = b;
        push_cmd.count    = CNT_W'(1);
        push_cmd.distance = ref_dist;
        push_cmd.last     = 1'b0;
        if (accept) begin
            if (s_data.start_req) begin
                hdr_idx_next   = 2'd1;
                remaining_next = '0;
                flag_next      = '0;
                tokens_next    = '0;
                ref_high_next  = '0;
            end else begin
                unique case (phase_reg)
                    FP_IDLE: ;
                    FP_HEADER: begin
                        case (hdr_idx_reg)
                            2'd1:    remaining_next[7:0]   = b;
                            2'd2:    remaining_next[15:8]  = b;
                            2'd3:    remaining_next[23:16] = b;
                            default: ;
                        endcase
                        if (hdr_done) begin
                            hdr_idx_next  = 2'd0;
                            push          = 1'b1;
                            push_cmd.kind = size_zero ? CMD_EMPTY : CMD_BEGIN;
                            push_cmd.last = 1'b1;
                        end else begin
                            hdr_idx_next = hdr_idx_reg + 2'd1;
                        end
                    end
                    FP_FLAG: begin
                        flag_next   = b;
                        tokens_next = 4'd8;
                    end
                    FP_TOKEN: begin
                        if (flag_reg[7]) begin
                            ref_high_next = b;
                        end else begin
                            push           = 1'b1;
                            push_cmd.last  = (remaining_reg == SIZE_W'(1));
                            remaining_next = remaining_reg - SIZE_W'(1);
                            flag_next      = {flag_reg[6:0], 1'b0};
                            tokens_next    = tokens_dec;
                        end
                    end
                    FP_REFLO: begin
                        push          = 1'b1;
                        push_cmd.kind = CMD_REF;
                        flag_next     = {flag_reg[6:0], 1'b0};
                        tokens_next   = tokens_dec;
                        if (ref_clipped) begin
                            push_cmd.count = remaining_reg[CNT_W-1:0];
                            push_cmd.last  = 1'b1;
                            remaining_next = '0;
                        end else begin
                            push_cmd.count = ref_len;
                            remaining_next = remaining_reg - SIZE_W'(ref_len);
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // parser registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= FP_IDLE;
            hdr_idx_reg   <= '0;
            remaining_reg <= '0;
            flag_reg      <= '0;
            tokens_reg    <= '0;
            ref_high_reg  <= '0;
        end else begin
            phase_reg     <= phase_next;
            hdr_idx_reg   <= hdr_idx_next;
            remaining_reg <= remaining_next;
            flag_reg      <= flag_next;
            tokens_reg    <= tokens_next;
            ref_high_reg  <= ref_high_next;
        end
    end

endmodule

/* rtl/lzd_back.sv */
// ----------------------------------------------------------------------------
// lzd_back
// Window expander: pops commands, copies history bytes out of the window
// RAM one at a time and drives the registered result channel.
// ----------------------------------------------------------------------------
module lzd_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  lzd_pkg::cmd_t         head_cmd,
    input  lzd_pkg::fifo_status_t status,
    output logic                  pop,
    output logic                  m_valid,
    input  logic                  m_ready,
    output lzd_pkg::out_item_t    m_data
);
    import lzd_pkg::*;

    back_state_t       state_reg, state_next;
    cmd_kind_t         kind_reg;
    logic [7:0]        lit_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [DIST_W-1:0] dist_reg;
    logic              last_reg;
    logic              pre_reg;
    logic [WIN_AW-1:0] ptr_reg;
    logic              filled_reg;
    logic              m_valid_reg;
    out_item_t         m_data_reg;

    logic              out_free;
    logic              emit;
    logic              win_we;
    logic              rd_en;
    logic [WIN_AW-1:0] rd_addr;
    logic [7:0]        rd_data;
    logic              pre_start;
    logic [7:0]        emit_byte;

    assign out_free  = !m_valid_reg || m_ready;
    assign pop       = (state_reg == BK_IDLE) && !status.empty;
    assign emit      = (state_reg == BK_EMIT) && out_free;
    assign win_we    = emit && (kind_reg != CMD_EMPTY);
    assign rd_en     = (state_reg == BK_READ);
    assign rd_addr   = ptr_reg - dist_reg[WIN_AW-1:0];
    assign pre_start = !filled_reg && ({1'b0, ptr_reg} < dist_reg);

    // byte source for the current result
    always_comb begin
        case (kind_reg)
            CMD_REF:   emit_byte = pre_reg ? 8'hFF : rd_data;
            CMD_EMPTY: emit_byte = 8'h00;
            default:   emit_byte = lit_reg;
        endcase
    end

    // history window
    lzd_ram #(
        .WIDTH (8),
        .DEPTH (WINDOW_DEPTH)
    ) u_window (
        .aclk  (aclk),
        .we    (win_we),
        .waddr (ptr_reg),
        .wdata (emit_byte),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE: begin
                if (pop) begin
                    unique case (head_cmd.kind) inside
                        CMD_LIT, CMD_EMPTY: state_next = BK_EMIT;
                        CMD_REF:            state_next = BK_READ;
                        default:            state_next = BK_IDLE;
                    endcase
                end
            end
            BK_READ: state_next = BK_EMIT;
            BK_EMIT: begin
                if (emit) begin
                    state_next = (cnt_reg == CNT_W'(1)) ? BK_IDLE : BK_READ;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_IDLE;
            ptr_reg     <= '0;
            filled_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (pop && (head_cmd.kind == CMD_BEGIN)) begin
                ptr_reg    <= '0;
                filled_reg <= 1'b0;
            end else if (win_we) begin
                ptr_reg <= ptr_reg + 1'b1;
                if (ptr_reg == '1) begin
                    filled_reg <= 1'b1;
                end
            end
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // command and result payload
    always_ff @(posedge aclk) begin
        if (pop) begin
            kind_reg <= head_cmd.kind;
            lit_reg  <= head_cmd.lit;
            cnt_reg  <= head_cmd.count;
            dist_reg <= head_cmd.distance;
            last_reg <= head_cmd.last;
        end else if (emit) begin
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
        if (rd_en) begin
            pre_reg <= pre_start;
        end
        if (emit) begin
            m_data_reg.out_byte  <= emit_byte;
            m_data_reg.last      <= last_reg && (cnt_reg == CNT_W'(1));
            m_data_reg.empty_res <= (kind_reg == CMD_EMPTY);
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

/* rtl/lz77_window_decompressor.sv */
// ----------------------------------------------------------------------------
// lz77_window_decompressor
// LZSS block decompressor with a 4096-byte history window.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel carries one compressed byte per transaction; start_req set on
//   the first header byte opens a new block and abandons any block in flight.
//   m_ channel carries one decompressed byte per transaction, last set on the
//   final byte; a zero-size block gives a single transaction with empty_res.
//   Bytes arriving while no block is open are dropped.
// Timing:
//   the parser takes one input byte per cycle while its 4-entry command
//   queue has room. The expander pops each command while idle, emits a
//   literal byte directly and handles each reference byte as a window RAM
//   read, then write/emit, so it finishes a command before popping the next.
//   A literal reaches m_ via the queue, command and result registers.
// Reset:
//   aresetn low clears the queue, parser and output valid; the window needs
//   no clearing pass since only bytes written in the current block are read.
// Stall:
//   when m_ready is low the result register holds, the expander waits, and
//   s_ready falls once the command queue fills.
// ----------------------------------------------------------------------------
module lz77_window_decompressor (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  lzd_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output lzd_pkg::out_item_t m_data
);
    import lzd_pkg::*;

    logic         push;
    cmd_t         push_cmd;
    logic         pop;
    cmd_t         head_cmd;
    fifo_status_t status;

    // stream parser
    lzd_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .push     (push),
        .push_cmd (push_cmd),
        .status   (status)
    );

    // command queue
    lzd_cmd_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .status   (status)
    );

    // window expander
    lzd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head_cmd (head_cmd),
        .status   (status),
        .pop      (pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

`ifndef SYNTHESIS
    // parser never queues into a full queue
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !status.full)
        else $error("command pushed into full queue");

    // expander never pops an empty queue
    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !status.empty)
        else $error("command popped from empty queue");

    // an empty-block result always closes the block
    a_empty_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.empty_res) |-> m_data.last)
        else $error("empty result without last");

    // a pop leaves the queue one entry emptier or refilled by a push
    a_pop_frees: assert property (@(posedge aclk) disable iff (!aresetn)
        (status.full && pop && !push) |=> !status.full)
        else $error("queue still full after pop");
`endif

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the lzss window decompressor. A short table of
// hand-built blocks is followed by random blocks generated against an
// in-bench expansion model, with random idling on both channels. Every
// output transaction is checked against the model's queue of bytes.
// ----------------------------------------------------------------------------
module tb;

    import lzd_pkg::*;

    // clock, reset and channel signals
    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    lz77_window_decompressor u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // directed blocks: zero size, truncated reference, reads before block
    // start, abandoned block, single byte block
    typedef struct packed {
        in_item_t  item;
        logic      typed;
        out_item_t result;
    } dir_row_t;

    localparam out_item_t NO_RES = '0;
    localparam int N_DIR = 29;
    localparam dir_row_t DIR_ROWS [N_DIR] = '{
        '{'{8'h55, 1'b0}, 1'b0, NO_RES},                  // idle byte, dropped
        '{'{8'hFF, 1'b1}, 1'b0, NO_RES},                  // zero size block
        '{'{8'h00, 1'b0}, 1'b0, NO_RES},
        '{'{8'h00, 1'b0}, 1'b0, NO_RES},
        '{'{8'h00, 1'b0}, 1'b1, '{8'h00, 1'b1, 1'b1}},
        '{'{8'h00, 1'b1}, 1'b0, NO_RES},                  // size 8
        '{'{8'h08, 1'b0}, 1'b0, NO_RES},
        '{'{8'h00, 1'b0}, 1'b0, NO_RES},
        '{'{8'h00, 1'b0}, 1'b0, NO_RES},
        '{'{8'h20, 1'b0}, 1'b0, NO_RES},                  // lit, lit, ref
        '{'{8'h00, 1'b0}, 1'b1, '{8'h00, 1'b0, 1'b0}},
        '{'{8'hFF, 1'b0}, 1'b1, '{8'hFF, 1'b0, 1'b0}},
        '{'{8'hF0, 1'b0}, 1'b0, NO_RES},                  // len 18, dist 2
        '{'{8'h01, 1'b0}, 1'b0, NO_RES},                  // cut at size
        '{'{8'hA5, 1'b0}, 1'b0, NO_RES},                  // after end, dropped
        '{'{8'h10, 1'b1}, 1'b0, NO_RES},                  // max size block
        '{'{8'hFF, 1'b0}, 1'b0, NO_RES},
        '{'{8'hFF, 1'b0}, 1'b0, NO_RES},
        '{'{8'hFF, 1'b0}, 1'b0, NO_RES},
        '{'{8'h80, 1'b0}, 1'b0, NO_RES},                  // ref then literals
        '{'{8'h0F, 1'b0}, 1'b0, NO_RES},                  // len 3, dist 4096
        '{'{8'hFF, 1'b0}, 1'b0, NO_RES},
        '{'{8'h3C, 1'b0}, 1'b1, '{8'h3C, 1'b0, 1'b0}},
        '{'{8'h10, 1'b1}, 1'b0, NO_RES},                  // abandons, size 1
        '{'{8'h01, 1'b0}, 1'b0, NO_RES},
        '{'{8'h00, 1'b0}, 1'b0, NO_RES},
        '{'{8'h00, 1'b0}, 1'b0, NO_RES},
        '{'{8'h00, 1'b0}, 1'b0, NO_RES},
        '{'{8'h7E, 1'b0}, 1'b1, '{8'h7E, 1'b1, 1'b0}}
    };

    // expansion model state
    logic [7:0]        hist [WINDOW_DEPTH];
    logic [SIZE_W-1:0] produced;
    logic [SIZE_W-1:0] left_count;
    front_phase_t      ph;
    logic [1:0]        hdr_idx;
    logic [7:0]        flags;
    logic [3:0]        tok_left;
    logic [7:0]        ref_hi;

    out_item_t   pending_out [$];
    int unsigned errors      = 0;
    int unsigned result_no   = 0;
    int unsigned sent_items  = 0;
    bit          burst       = 1'b0;
    out_item_t   want;

    task automatic report_mismatch(input string msg);
        errors++;
        // keep the log short when everything goes wrong
        if (errors <= 40)
            $display("[%0t] mismatch: %s", $time, msg);
    endtask

    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function void model_reset();
        foreach (hist[j])
            hist[j] = '0;
        produced   = '0;
        left_count = '0;
        ph         = FP_IDLE;
        hdr_idx    = '0;
        flags      = '0;
        tok_left   = '0;
        ref_hi     = '0;
    endfunction

    // one output byte into the history and the queue of expected bytes
    function void emit_byte(input logic [7:0] b, output bit done);
        hist[produced[WIN_AW-1:0]] = b;
        produced   = produced + 1'b1;
        left_count = left_count - 1'b1;
        done       = (left_count == '0);
        pending_out.push_back('{out_byte: b, last: done, empty_res: 1'b0});
        if (done)
            ph = FP_IDLE;
    endfunction

    function void next_token();
        flags    = flags << 1;
        tok_left = tok_left - 4'd1;
        ph       = (tok_left == '0) ? FP_FLAG : FP_TOKEN;
    endfunction

    // expected output bytes for one accepted input transaction
    function void lzss_step(input in_item_t it);
        logic [15:0]       code;
        logic [4:0]        len;
        logic [DIST_W-1:0] distance;
        logic [WIN_AW-1:0] slot;
        logic [7:0]        v;
        int unsigned       k;
        bit                done;

        // start opens a block whatever the phase
        if (it.start_req) begin
            produced   = '0;
            left_count = '0;
            flags      = '0;
            tok_left   = '0;
            ref_hi     = '0;
            hdr_idx    = 2'd1;
            ph         = FP_HEADER;
            return;
        end

        case (ph)
            FP_HEADER: begin
                left_count = left_count
                           | (SIZE_W'(it.in_byte) << (8 * (int'(hdr_idx) - 1)));
                if (hdr_idx < 2'd3) begin
                    hdr_idx = hdr_idx + 2'd1;
                end else begin
                    hdr_idx  = '0;
                    produced = '0;
                    if (left_count == '0) begin
                        pending_out.push_back('{out_byte: 8'h00, last: 1'b1,
                                                empty_res: 1'b1});
                        ph = FP_IDLE;
                    end else begin
                        ph = FP_FLAG;
                    end
                end
            end
            FP_FLAG: begin
                flags    = it.in_byte;
                tok_left = 4'd8;
                ph       = FP_TOKEN;
            end
            FP_TOKEN: begin
                if (flags[7]) begin
                    ref_hi = it.in_byte;
                    ph     = FP_REFLO;
                end else begin
                    emit_byte(it.in_byte, done);
                    if (!done)
                        next_token();
                end
            end
            FP_REFLO: begin
                code     = {ref_hi, it.in_byte};
                len      = 5'(code[15:12]) + 5'(LEN_BIAS);
                distance = {1'b0, code[11:0]} + 1'b1;
                done     = 1'b0;
                for (k = 0; k < len && !done; k++) begin
                    // bytes before the block start read as 0xff
                    if (produced < distance) begin
                        v = 8'hFF;
                    end else begin
                        slot = produced[WIN_AW-1:0] - distance[WIN_AW-1:0];
                        v    = hist[slot];
                    end
                    emit_byte(v, done);
                end
                if (!done)
                    next_token();
            end
            default: ph = FP_IDLE;
        endcase
    endfunction

    // one input transaction, then an optional gap
    task automatic drive_item(input in_item_t it);
        int unsigned gap;
        s_data  <= it;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        gap = burst ? 0 : idle_len();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // hold the input side until every expected byte is out
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_out.size() != 0);
    endtask

    // one block built from the model's phase; cut abandons it early
    task automatic feed_block(input int unsigned size, input int unsigned ref_pct,
                              input bit long_refs, input int unsigned cut);
        int unsigned n;
        int unsigned reach;
        int unsigned d;
        int unsigned r;
        int          i;
        logic [7:0]  b;
        logic [7:0]  lo_byte;
        logic [11:0] d_m1;
        in_item_t    it;

        lo_byte = '0;
        it = '{in_byte: 8'($urandom), start_req: 1'b1};
        lzss_step(it);
        drive_item(it);
        sent_items++;
        n = 1;
        while (ph != FP_IDLE && n < cut) begin
            case (ph)
                FP_HEADER: b = 8'(size >> (8 * (int'(hdr_idx) - 1)));
                FP_FLAG: begin
                    for (i = 0; i < 8; i++)
                        b[i] = ($urandom_range(0, 99) < ref_pct);
                end
                FP_TOKEN: begin
                    if (flags[7]) begin
                        // mostly near copies, some across the whole window
                        reach = (produced > WINDOW_DEPTH) ? WINDOW_DEPTH : produced;
                        r = $urandom_range(0, 9);
                        if (reach != 0 && r < 5)
                            d = $urandom_range(1, (reach < 64) ? reach : 64);
                        else if (reach != 0 && r < 8)
                            d = $urandom_range(1, reach);
                        else
                            d = $urandom_range(1, WINDOW_DEPTH);
                        d_m1    = 12'(d - 1);
                        b       = {long_refs ? 4'hF : 4'($urandom), d_m1[11:8]};
                        lo_byte = d_m1[7:0];
                    end else begin
                        b = 8'($urandom);
                    end
                end
                FP_REFLO: b = lo_byte;
                default:  b = 8'($urandom);
            endcase
            it = '{in_byte: b, start_req: 1'b0};
            lzss_step(it);
            drive_item(it);
            sent_items++;
            n++;
        end
    endtask

    // output side: random stalls with calm stretches
    initial begin
        int unsigned stall_left;
        int unsigned calm_left;
        int unsigned r;
        stall_left = 0;
        calm_left  = 0;
        wait (aresetn);
        forever begin
            @(posedge aclk);
            if (calm_left != 0) begin
                calm_left--;
                m_ready <= 1'b1;
            end else if (stall_left != 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                r = $urandom_range(0, 99);
                if (r < 3)
                    calm_left = $urandom_range(50, 200);
                else if (r < 30)
                    stall_left = idle_len();
            end
        end
    end

    // check each output transaction against the oldest expected byte
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            result_no++;
            if (pending_out.size() == 0) begin
                report_mismatch($sformatf("result %0d with nothing expected, byte %02h",
                                          result_no, m_data.out_byte));
            end else begin
                want = pending_out.pop_front();
                if (m_data.out_byte !== want.out_byte)
                    report_mismatch($sformatf("result %0d out_byte %02h, want %02h",
                                              result_no, m_data.out_byte, want.out_byte));
                if (m_data.last !== want.last)
                    report_mismatch($sformatf("result %0d last %b, want %b",
                                              result_no, m_data.last, want.last));
                if (m_data.empty_res !== want.empty_res)
                    report_mismatch($sformatf("result %0d empty_res %b, want %b",
                                              result_no, m_data.empty_res,
                                              want.empty_res));
            end
        end
    end

    // stimulus
    initial begin
        int unsigned i;
        int unsigned n0;
        int unsigned base;
        int unsigned size;
        int unsigned r;
        int unsigned cut;
        in_item_t    extra;

        model_reset();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table; typed rows replace the model's bytes
        for (i = 0; i < N_DIR; i++) begin
            n0 = pending_out.size();
            lzss_step(DIR_ROWS[i].item);
            if (DIR_ROWS[i].typed) begin
                while (pending_out.size() > n0)
                    void'(pending_out.pop_back());
                pending_out.push_back(DIR_ROWS[i].result);
            end
            drive_item(DIR_ROWS[i].item);
        end
        wait_drained();

        // random blocks, some abandoned, with idle bytes in between
        base = sent_items;
        while (sent_items - base < 400) begin
            burst = ($urandom_range(0, 4) == 0);
            r = $urandom_range(0, 99);
            if (r < 5)
                size = 0;
            else if (r < 75)
                size = $urandom_range(1, 24);
            else if (r < 95)
                size = $urandom_range(25, 120);
            else
                size = $urandom_range(121, 600);
            cut = ($urandom_range(0, 7) == 0) ? $urandom_range(2, 12) : 32'hFFFF_FFFF;
            feed_block(size, $urandom_range(10, 90), ($urandom_range(0, 3) == 0), cut);
            if ($urandom_range(0, 5) == 0) begin
                repeat ($urandom_range(1, 3)) begin
                    extra = '{in_byte: 8'($urandom), start_req: 1'b0};
                    lzss_step(extra);
                    drive_item(extra);
                    sent_items++;
                end
            end
            if ($urandom_range(0, 9) == 0)
                wait_drained();
        end
        burst = 1'b0;

        // drain and watch for stray output
        wait_drained();
        repeat (200) @(posedge aclk);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // run limit
    initial begin
        #40_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

/* sim.f */
rtl/lzd_pkg.sv
rtl/lzd_ram.sv
rtl/lzd_cmd_fifo.sv
rtl/lzd_front.sv
rtl/lzd_back.sv
rtl/lz77_window_decompressor.sv
tb/tb.sv
